[sv/mcbd_pkg.sv]
// ----------------------------------------------------------------------------
// mcbd_pkg
// Shared constants and types for the 2x2 box-filter mip chain generator.
// ----------------------------------------------------------------------------
package mcbd_pkg;

   localparam int DEF_MAX_SIZE_LOG2 = 11;
   localparam int DEF_CHANNELS      = 4;

   localparam int NUM_CH  = 4;
   localparam int CH_W    = 8;
   localparam int SUM_W   = CH_W + 1;
   localparam int SIZE_W  = 4;
   localparam int LEVEL_W = 4;
   localparam int COORD_W = 10;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WAIT = 3'b010,
      ST_CALC = 3'b100
   } state_type;

endpackage

[sv/mcbd_if.sv]
// ----------------------------------------------------------------------------
// mcbd_if
// Valid/ready channels of the mip chain generator: texel in, mip texel out,
// and the size register write channel.
// ----------------------------------------------------------------------------
interface mcbd_req_if;
   import mcbd_pkg::*;
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] chan0;
   logic [CH_W-1:0] chan1;
   logic [CH_W-1:0] chan2;
   logic [CH_W-1:0] chan3;

   modport source (output valid, chan0, chan1, chan2, chan3, input ready);
   modport sink   (input valid, chan0, chan1, chan2, chan3, output ready);
endinterface

interface mcbd_rsp_if;
   import mcbd_pkg::*;
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] level;
   logic [COORD_W-1:0] col;
   logic [COORD_W-1:0] row;
   logic [CH_W-1:0]    out0;
   logic [CH_W-1:0]    out1;
   logic [CH_W-1:0]    out2;
   logic [CH_W-1:0]    out3;
   logic               last_of_run;

   modport source (output valid, level, col, row, out0, out1, out2, out3, last_of_run,
                   input ready);
   modport sink   (input valid, level, col, row, out0, out1, out2, out3, last_of_run,
                   output ready);
endinterface

interface mcbd_csr_if;
   import mcbd_pkg::*;
   logic              valid;
   logic              ready;
   logic [SIZE_W-1:0] size_log2;

   modport source (output valid, size_log2, input ready);
   modport sink   (input valid, size_log2, output ready);
endinterface

[sv/mip_chain_box_downsample.sv]
// ----------------------------------------------------------------------------
// mip_chain_box_downsample
// Streams a square RGBA8 base level in raster order and emits every texel of
// the smaller mip levels as soon as its 2x2 quad completes.
// ----------------------------------------------------------------------------
// Flow: a base texel is taken in ST_IDLE and is stored, combined or averaged in
// ST_CALC, where a completed quad's texel is registered onto the result channel;
// below the top level that texel passes through ST_WAIT and ST_CALC once more,
// since the next level must then store or combine it. A new base texel is taken
// only in ST_IDLE, once the previous cascade is done; each level costs one read of
// the hold and line memories, and a result beat that is not taken stalls the chain.
// Reset: size returns to 8 texel log2, position to (0,0); memories keep their
// contents, every entry is written before the raster order reads it.
module mip_chain_box_downsample #(
   parameter int MAX_SIZE_LOG2 = mcbd_pkg::DEF_MAX_SIZE_LOG2,
   parameter int CHANNELS      = mcbd_pkg::DEF_CHANNELS
) (
   input logic         clock,
   input logic         reset,
   mcbd_req_if.sink    req,
   mcbd_rsp_if.source  rsp,
   mcbd_csr_if.sink    csr
);
   import mcbd_pkg::*;

   localparam int POS_W      = MAX_SIZE_LOG2;
   localparam int LINE_DEPTH = 1 << MAX_SIZE_LOG2;
   localparam int K_W        = $clog2(MAX_SIZE_LOG2 + 1);
   localparam int HOLD_AW    = (MAX_SIZE_LOG2 > 1) ? $clog2(MAX_SIZE_LOG2) : 1;
   localparam int HOLD_W     = NUM_CH * CH_W;
   localparam int LINE_W     = NUM_CH * SUM_W;

   state_type                     state_ff, state_in;
   logic [SIZE_W-1:0]             size_ff, size_in;
   logic [POS_W-1:0]              col_ff, col_in;
   logic [POS_W-1:0]              row_ff, row_in;
   logic [K_W-1:0]                k_ff, k_in;
   logic [NUM_CH-1:0][CH_W-1:0]   cur_ff, cur_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]            level_ff, level_in;
   logic [COORD_W-1:0]            ocol_ff, ocol_in;
   logic [COORD_W-1:0]            orow_ff, orow_in;
   logic [NUM_CH-1:0][CH_W-1:0]   oval_ff, oval_in;
   logic                          olast_ff, olast_in;

   logic [K_W-1:0]                lg;
   logic [POS_W:0]                edge_len;
   logic [POS_W-1:0]              x, y, x_up, y_up;
   logic [POS_W:0]                line_sum;
   logic [POS_W-1:0]              line_addr;
   logic [HOLD_AW-1:0]            hold_addr;
   logic [HOLD_W-1:0]             hold_rdata;
   logic [LINE_W-1:0]             line_rdata;
   logic [NUM_CH-1:0][SUM_W-1:0]  ps;
   logic [NUM_CH-1:0][CH_W-1:0]   avg;
   logic [K_W-1:0]                k_next;
   logic                          last;
   logic                          slot_free;
   logic                          hold_we, line_we, done, load;
   logic [SUM_W:0]                quad;
   logic [SUM_W:0]                quad_rnd;

   // Effective size, clamped into the supported range.
   always_comb begin
      if (size_ff == '0) begin
         lg = K_W'(1);
      end else if (int'(size_ff) > MAX_SIZE_LOG2) begin
         lg = K_W'(MAX_SIZE_LOG2);
      end else begin
         lg = K_W'(size_ff);
      end
   end

   assign edge_len  = (POS_W + 1)'(1) << lg;
   assign x         = col_ff >> k_ff;
   assign y         = row_ff >> k_ff;
   assign x_up      = x >> 1;
   assign y_up      = y >> 1;
   // Level k keeps its pair sums in the region that starts at S - (S >> k).
   assign line_sum  = (edge_len - (edge_len >> k_ff)) + (POS_W + 1)'(x_up);
   assign line_addr = line_sum[POS_W-1:0];
   assign hold_addr = HOLD_AW'(k_ff);
   assign k_next    = k_ff + K_W'(1);
   assign last      = (k_next == lg) || !x_up[0] || !y_up[0];
   assign slot_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      quad     = '0;
      quad_rnd = '0;
      for (int c = 0; c < NUM_CH; c++) begin
         ps[c]    = {1'b0, hold_rdata[c*CH_W +: CH_W]} + {1'b0, cur_ff[c]};
         quad     = {1'b0, line_rdata[c*SUM_W +: SUM_W]} + {1'b0, ps[c]};
         quad_rnd = quad + (SUM_W + 1)'(2);
         avg[c]   = (c < CHANNELS) ? quad_rnd[SUM_W:2] : '0;
      end
   end

   mcbd_ram #(
      .WIDTH (HOLD_W),
      .DEPTH (MAX_SIZE_LOG2)
   ) u_hold_ram (
      .clock (clock),
      .we    (hold_we),
      .waddr (hold_addr),
      .wdata (cur_ff),
      .raddr (hold_addr),
      .rdata (hold_rdata)
   );

   mcbd_ram #(
      .WIDTH (LINE_W),
      .DEPTH (LINE_DEPTH)
   ) u_line_ram (
      .clock (clock),
      .we    (line_we),
      .waddr (line_addr),
      .wdata (ps),
      .raddr (line_addr),
      .rdata (line_rdata)
   );

   assign req.ready = (state_ff == ST_IDLE) && !csr.valid;
   assign csr.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      size_in      = size_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      k_in         = k_ff;
      cur_in       = cur_ff;
      level_in     = level_ff;
      ocol_in      = ocol_ff;
      orow_in      = orow_ff;
      oval_in      = oval_ff;
      olast_in     = olast_ff;
      hold_we      = 1'b0;
      line_we      = 1'b0;
      done         = 1'b0;
      load         = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;

      case (state_ff)
         ST_IDLE: begin
            if (csr.valid) begin
               size_in = csr.size_log2;
               col_in  = '0;
               row_in  = '0;
            end else if (req.valid) begin
               cur_in[0] = (0 < CHANNELS) ? req.chan0 : '0;
               cur_in[1] = (1 < CHANNELS) ? req.chan1 : '0;
               cur_in[2] = (2 < CHANNELS) ? req.chan2 : '0;
               cur_in[3] = (3 < CHANNELS) ? req.chan3 : '0;
               state_in  = ST_CALC;
            end
         end
         ST_WAIT: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            if (!x[0]) begin
               hold_we = 1'b1;
               done    = 1'b1;
            end else if (!y[0]) begin
               line_we = 1'b1;
               done    = 1'b1;
            end else if (slot_free) begin
               load   = 1'b1;
               cur_in = avg;
               // Below the top level the new texel still has to be stored
               // or combined one level up, even when it is the last beat.
               if (k_next == lg) begin
                  done = 1'b1;
               end else begin
                  k_in     = k_next;
                  state_in = ST_WAIT;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
         level_in     = LEVEL_W'(k_next);
         ocol_in      = COORD_W'(x_up);
         orow_in      = COORD_W'(y_up);
         oval_in      = avg;
         olast_in     = last;
      end

      if (done) begin
         k_in     = '0;
         state_in = ST_IDLE;
         if ((POS_W + 1)'(col_ff) + (POS_W + 1)'(1) == edge_len) begin
            col_in = '0;
            if ((POS_W + 1)'(row_ff) + (POS_W + 1)'(1) == edge_len) begin
               row_in = '0;
            end else begin
               row_in = row_ff + POS_W'(1);
            end
         end else begin
            col_in = col_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= SIZE_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      level_ff <= level_in;
      ocol_ff  <= ocol_in;
      orow_ff  <= orow_in;
      oval_ff  <= oval_in;
      olast_ff <= olast_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.level       = level_ff;
   assign rsp.col         = ocol_ff;
   assign rsp.row         = orow_ff;
   assign rsp.out0        = oval_ff[0];
   assign rsp.out1        = oval_ff[1];
   assign rsp.out2        = oval_ff[2];
   assign rsp.out3        = oval_ff[3];
   assign rsp.last_of_run = olast_ff;

endmodule

[sv/mcbd_ram.sv]
// ----------------------------------------------------------------------------
// mcbd_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module mcbd_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[verif/mip_chain_box_downsample_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mip_chain_box_downsample_test
// Streams base-level texels of several texture sizes into the mip chain
// generator and checks every emitted mip texel against a local predictor.
// The predictor keeps its own pair-sum lines and left-texel holds.
// ----------------------------------------------------------------------------
module mip_chain_box_downsample_test;
   import mcbd_pkg::*;

   localparam int MAX_LOG2      = DEF_MAX_SIZE_LOG2;
   localparam int LINE_DEPTH    = 1 << MAX_LOG2;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 300;
   localparam int IDLE_PCT      = 34;
   localparam int CYCLE_LIMIT   = 200000;

   typedef logic [NUM_CH-1:0][CH_W-1:0] texel_type;

   typedef struct {
      logic [LEVEL_W-1:0] level;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      texel_type          px;
      logic               last;
   } mip_texel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mcbd_req_if req_ch();
   mcbd_rsp_if rsp_ch();
   mcbd_csr_if csr_ch();

   mip_chain_box_downsample u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   texel_type     texel_queue[$];
   mip_texel_type mip_expect[$];

   // Predictor state.
   logic [SIZE_W-1:0]            size_reg;
   int                           pos_col;
   int                           pos_row;
   logic [NUM_CH-1:0][SUM_W-1:0] pair_sums [LINE_DEPTH];
   texel_type                    left_hold [MAX_LOG2];

   bit req_fire  = 1'b0;
   bit steady    = 1'b0;
   bit hold_arm  = 1'b0;
   bit hold_done = 1'b0;
   int hold_left = 0;
   int mismatches = 0;
   int cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("mip_chain_box_downsample_test failed");
         $finish;
      end
   end

   // Computes the mip texels that one accepted base texel completes and
   // advances the raster position.
   function automatic void predict_mips(input texel_type texel);
      int                           lg;
      int                           side;
      int                           x;
      int                           y;
      int                           idx;
      int                           q;
      texel_type                    cur;
      logic [NUM_CH-1:0][SUM_W-1:0] psum;
      mip_texel_type                found;
      bit                           have_found;
      bit                           stop;
      lg = (size_reg < 1) ? 1 : (size_reg > MAX_LOG2) ? MAX_LOG2 : int'(size_reg);
      side = 1 << lg;
      cur = texel;
      have_found = 1'b0;
      stop = 1'b0;
      for (int k = 0; k < lg && !stop; k++) begin
         x = pos_col >> k;
         y = pos_row >> k;
         if (x % 2 == 0) begin
            left_hold[k] = cur;
            stop = 1'b1;
         end else begin
            for (int c = 0; c < NUM_CH; c++)
               psum[c] = left_hold[k][c] + cur[c];
            idx = (side - (side >> k) + (x >> 1)) % LINE_DEPTH;
            if (y % 2 == 0) begin
               pair_sums[idx] = psum;
               stop = 1'b1;
            end else begin
               for (int c = 0; c < NUM_CH; c++) begin
                  q = pair_sums[idx][c] + psum[c];
                  cur[c] = CH_W'((q + 2) >> 2);
               end
               // The previous level's texel is known not to be the last one.
               if (have_found)
                  mip_expect.insert(mip_expect.size(), found);
               found.level = LEVEL_W'(k + 1);
               found.col   = COORD_W'(x >> 1);
               found.row   = COORD_W'(y >> 1);
               found.px    = cur;
               found.last  = 1'b0;
               have_found  = 1'b1;
            end
         end
      end
      if (have_found) begin
         found.last = 1'b1;
         mip_expect.insert(mip_expect.size(), found);
      end
      pos_col++;
      if (pos_col >= side) begin
         pos_col = 0;
         pos_row++;
         if (pos_row >= side)
            pos_row = 0;
      end
   endfunction

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endfunction

   function automatic void check_mip_texel();
      mip_texel_type want;
      if (mip_expect.size() == 0) begin
         $error("mip texel beat with nothing expected: level %0d col %0d row %0d",
                rsp_ch.level, rsp_ch.col, rsp_ch.row);
         mismatches++;
      end else begin
         want = mip_expect.pop_front();
         check_field("level", want.level, rsp_ch.level);
         check_field("col", want.col, rsp_ch.col);
         check_field("row", want.row, rsp_ch.row);
         check_field("out0", want.px[0], rsp_ch.out0);
         check_field("out1", want.px[1], rsp_ch.out1);
         check_field("out2", want.px[2], rsp_ch.out2);
         check_field("out3", want.px[3], rsp_ch.out3);
         check_field("last_of_run", want.last, rsp_ch.last_of_run);
      end
   endfunction

   // Monitor: checks result beats, tracks register writes and predicts.
   always @(posedge clock) begin
      req_fire <= req_ch.valid && req_ch.ready;
      if (reset) begin
         size_reg = SIZE_RESET;
         pos_col  = 0;
         pos_row  = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready)
            check_mip_texel();
         if (csr_ch.valid && csr_ch.ready) begin
            size_reg = csr_ch.size_log2;
            pos_col  = 0;
            pos_row  = 0;
         end
         if (req_ch.valid && req_ch.ready)
            predict_mips({req_ch.chan3, req_ch.chan2, req_ch.chan1, req_ch.chan0});
      end
   end

   // Driver: offers the next pending texel once the previous beat is taken.
   always @(negedge clock) begin
      texel_type t;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_fire) begin
         if (texel_queue.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
            t = texel_queue.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.chan0 <= t[0];
            req_ch.chan1 <= t[1];
            req_ch.chan2 <= t[2];
            req_ch.chan3 <= t[3];
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Result side ready, with one long hold-off so the block backs up.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left--;
      end else if (hold_arm && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= steady || $urandom_range(99) >= IDLE_PCT;
      end
   end

   function automatic texel_type random_texel();
      texel_type t;
      for (int c = 0; c < NUM_CH; c++) begin
         case ($urandom_range(7))
            0: t[c] = '0;
            1: t[c] = '1;
            default: t[c] = CH_W'($urandom_range(255));
         endcase
      end
      return t;
   endfunction

   task automatic add_texel(input texel_type t);
      texel_queue.insert(texel_queue.size(), t);
   endtask

   task automatic queue_random(input int count);
      for (int i = 0; i < count; i++)
         add_texel(random_texel());
   endtask

   task automatic set_size(input logic [SIZE_W-1:0] value);
      @(negedge clock);
      csr_ch.valid     <= 1'b1;
      csr_ch.size_log2 <= value;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Waits until every texel is taken and every mip texel has arrived, then
   // lets a texel that completes no quad finish inside the block.
   task automatic settle();
      do @(posedge clock);
      while (texel_queue.size() != 0 || req_ch.valid || mip_expect.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      req_ch.valid     = 1'b0;
      req_ch.chan0     = '0;
      req_ch.chan1     = '0;
      req_ch.chan2     = '0;
      req_ch.chan3     = '0;
      rsp_ch.ready     = 1'b0;
      csr_ch.valid     = 1'b0;
      csr_ch.size_log2 = '0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A few texels at the reset size: all on row 0, so no quad completes.
      queue_random(3);
      settle();

      // Smallest texture: all zero, all full scale, then a quad that checks
      // round-half-up and the top of the range per channel.
      set_size(1);
      repeat (4) add_texel('0);
      repeat (4) add_texel('1);
      add_texel({8'd3, 8'd255, 8'd1, 8'd1});
      add_texel({8'd0, 8'd255, 8'd1, 8'd0});
      add_texel({8'd0, 8'd255, 8'd0, 8'd0});
      add_texel({8'd0, 8'd254, 8'd0, 8'd0});
      settle();

      // A size below the range acts as the smallest one.
      set_size(0);
      queue_random(4);
      settle();

      // Two whole textures back to back with no idling on either side.
      steady = 1'b1;
      set_size(2);
      queue_random(32);
      settle();
      steady = 1'b0;

      set_size(3);
      hold_arm = 1'b1;
      queue_random(64);
      settle();

      set_size(1);
      queue_random(8);
      settle();

      // Cut a texture short; the next write starts over at the origin.
      set_size(4);
      queue_random(20);
      settle();

      set_size(MAX_LOG2);
      queue_random(6);
      settle();

      // A size above the range acts as the largest one.
      set_size(4'hF);
      queue_random(6);
      settle();

      set_size(2);
      queue_random(8);
      settle();

      if (mismatches == 0)
         $display("mip_chain_box_downsample_test passed");
      else
         $display("mip_chain_box_downsample_test failed");
      $finish;
   end

endmodule
